// ===== sv/ssd_pkg.sv =====
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int FIELD_COUNT = 5;
  localparam int SEG_BITS    = 8;

  localparam logic [7:0] SEG_DOT   = 8'h01;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  typedef logic [7:0] seg_t;

  localparam seg_t DIGIT_SEG [10] = '{
    8'hBE, 8'h06, 8'hEA, 8'h6E, 8'h56, 8'h7C, 8'hFC, 8'h0E, 8'hFE, 8'h7E
  };

  localparam seg_t LETTER_SEG [26] = '{
    8'hDE, 8'hF4, 8'hB8, 8'hE6, 8'hF8, 8'hD8, 8'hBC, 8'hD6, 8'h06, 8'hA6,
    8'h40, 8'hB0, 8'h40, 8'hC4, 8'hE4, 8'hDA, 8'h40, 8'hC0, 8'h7C, 8'hF0,
    8'hA4, 8'h40, 8'h40, 8'h40, 8'h76, 8'h40
  };

  // queue fill status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } ssd_q_stat_t;

  function automatic seg_t char_seg(input logic [7:0] c);
    logic [7:0] up_idx;
    logic [7:0] lo_idx;
    logic [7:0] dg_idx;
    seg_t       seg;
    up_idx = c - CHAR_UPPER_A;
    lo_idx = c - CHAR_LOWER_A;
    dg_idx = c - CHAR_ZERO;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      seg = LETTER_SEG[up_idx[4:0]];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      seg = LETTER_SEG[lo_idx[4:0]];
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      seg = DIGIT_SEG[dg_idx[3:0]];
    end else if (c == CHAR_MINUS) begin
      seg = SEG_MINUS;
    end else begin
      seg = SEG_BLANK;
    end
    return seg;
  endfunction

endpackage

// ===== sv/ssd_front.sv =====
`timescale 1ns / 1ps

module ssd_front
  import ssd_pkg::*;
#(
  parameter int NCH = 5
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_text_char0,
  input  logic [7:0]            in_text_char1,
  input  logic [7:0]            in_text_char2,
  input  logic [7:0]            in_text_char3,
  input  logic [7:0]            in_text_char4,
  input  logic [7:0]            in_dot_position,
  input  ssd_q_stat_t           q_stat,
  output logic                  q_push,
  output logic [NCH*SEG_BITS-1:0] q_wdata
);

  logic [7:0] chars [FIELD_COUNT];

  assign chars[0] = in_text_char0;
  assign chars[1] = in_text_char1;
  assign chars[2] = in_text_char2;
  assign chars[3] = in_text_char3;
  assign chars[4] = in_text_char4;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  // position 0 is the last character, shifted out first
  for (genvar pos = 0; pos < NCH; pos++) begin : g_pos
    always_comb begin
      q_wdata[pos*SEG_BITS +: SEG_BITS] = char_seg(chars[NCH-1-pos]);
      if (in_dot_position == 8'(pos)) begin
        q_wdata[pos*SEG_BITS +: SEG_BITS] = char_seg(chars[NCH-1-pos]) | SEG_DOT;
      end
    end
  end

endmodule

// ===== sv/ssd_queue.sv =====
`timescale 1ns / 1ps

module ssd_queue
  import ssd_pkg::*;
#(
  parameter int WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output ssd_q_stat_t      stat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/ssd_back.sv =====
`timescale 1ns / 1ps

module ssd_back
  import ssd_pkg::*;
#(
  parameter int WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ssd_q_stat_t      q_stat,
  input  logic [WIDTH-1:0] q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_serial_bit,
  output logic             out_latch_pulse,
  output logic             out_last
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam logic [CW-1:0] LATCH_CNT = CW'(WIDTH);

  logic             busy_r;
  logic             busy_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [WIDTH-1:0] shift_r;
  logic [WIDTH-1:0] shift_nxt;
  logic             valid_r;
  logic             valid_nxt;
  logic             bit_r;
  logic             bit_nxt;
  logic             latch_r;
  logic             latch_nxt;
  logic             adv;
  logic             at_latch;

  assign adv      = !valid_r || out_ready;
  assign at_latch = (cnt_r == LATCH_CNT);
  assign q_pop    = adv && (!busy_r || at_latch) && !q_stat.empty;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    valid_nxt = valid_r;
    bit_nxt   = bit_r;
    latch_nxt = latch_r;
    if (adv) begin
      valid_nxt = busy_r;
      if (busy_r) begin
        if (at_latch) begin
          bit_nxt   = 1'b0;
          latch_nxt = 1'b1;
          busy_nxt  = 1'b0;
        end else begin
          bit_nxt   = shift_r[0];
          latch_nxt = 1'b0;
          shift_nxt = shift_r >> 1;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      if (q_pop) begin
        busy_nxt  = 1'b1;
        cnt_nxt   = '0;
        shift_nxt = q_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bit_r   <= bit_nxt;
    latch_r <= latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_serial_bit  = bit_r;
  assign out_latch_pulse = latch_r;
  assign out_last        = latch_r;

endmodule

// ===== sv/seven_segment_text_shift_out.sv =====
`timescale 1ns / 1ps

// seven-segment text shift-out driver
// input channel: one request per frame, five ascii characters plus a dot
// position (0 = last character, CHAR_COUNT or more = no dot)
// output channel: per frame, 8 bits per character, last character first and
// each pattern lsb first, then one latch result with latch_pulse and last set
// a frame is 8 * NCH + 1 output results (NCH = CHAR_COUNT clamped to 1..5),
// 41 at the default size; the output shift counter sends one result per cycle
// unless out_ready stalls it, and sets the frame length
// throughput: back-to-back frames stream with no gap on the output; the
// front end maps characters and queues up to two frames, so a new request is
// taken while the back end is still shifting the previous one
// reset: synchronous active-low rst_n empties the queue and drops out_valid
// receiver stall: the output register holds its result while out_ready is
// low; once the queue fills, in_ready drops until the back end drains it
module seven_segment_text_shift_out
  import ssd_pkg::*;
#(
  parameter int CHAR_COUNT = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_char0,
  input  logic [7:0] in_text_char1,
  input  logic [7:0] in_text_char2,
  input  logic [7:0] in_text_char3,
  input  logic [7:0] in_text_char4,
  input  logic [7:0] in_dot_position,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_serial_bit,
  output logic       out_latch_pulse,
  output logic       out_last
);

  localparam int NCH   = (CHAR_COUNT < 1) ? 1 :
                         (CHAR_COUNT > FIELD_COUNT) ? FIELD_COUNT : CHAR_COUNT;
  localparam int WIDTH = NCH * SEG_BITS;

  ssd_q_stat_t      q_stat;
  logic             q_push;
  logic             q_pop;
  logic [WIDTH-1:0] q_wdata;
  logic [WIDTH-1:0] q_rdata;

  ssd_front #(
    .NCH (NCH)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_char0   (in_text_char0),
    .in_text_char1   (in_text_char1),
    .in_text_char2   (in_text_char2),
    .in_text_char3   (in_text_char3),
    .in_text_char4   (in_text_char4),
    .in_dot_position (in_dot_position),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  ssd_queue #(
    .WIDTH (WIDTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ssd_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_serial_bit  (out_serial_bit),
    .out_latch_pulse (out_latch_pulse),
    .out_last        (out_last)
  );

endmodule

// ===== sv/ssd_checker.sv =====
`timescale 1ns / 1ps

module ssd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_serial_bit,
  input logic out_latch_pulse,
  input logic out_last
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> in_valid)
    else $error("request dropped before it was accepted");

  a_last_is_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_latch_pulse))
    else $error("last and latch_pulse disagree");

  a_latch_data_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_latch_pulse) |-> !out_serial_bit)
    else $error("latch result carries a data bit");

  a_no_double_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_latch_pulse) |=> !(out_valid && out_latch_pulse))
    else $error("two latch results in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_serial_bit) && $stable(out_latch_pulse)))
    else $error("stalled result changed");

endmodule

bind seven_segment_text_shift_out ssd_checker u_ssd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_serial_bit  (out_serial_bit),
  .out_latch_pulse (out_latch_pulse),
  .out_last        (out_last)
);
